// File: rtl/button_debounce_hold_detector_defines.svh
// ---------------------------------------------------------------------------
// Button debounce and hold detector assertion macros
// Shared assertion forms for the debounce block.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_HOLD_DETECTOR_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BDHD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BDHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bdhd_pkg.sv
// ---------------------------------------------------------------------------
// Button debounce and hold detector package
// Transfer types, item kinds, event codes and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package bdhd_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned MS_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_CLEAR  = 2'd1,
      KIND_START  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_PRESSED  = 2'd1,
      EV_RELEASED = 2'd2,
      EV_HELD     = 2'd3
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUTTON_PRESENT = 2'd0,
      CSR_ACTIVE_LOW     = 2'd1,
      CSR_DEBOUNCE_MS    = 2'd2,
      CSR_HOLD_MS        = 2'd3
   } csr_index_type;

   localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [MS_W-1:0] HOLD_RESET     = 16'd0;

   typedef struct packed {
      logic [1:0]        kind;
      logic              pin_level;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]        event_res;
      logic              pressed;
      logic [TIME_W-1:0] hold_time;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/button_debounce_hold_detector.sv
// ---------------------------------------------------------------------------
// Button debounce and hold detector
// Timestamp-based debouncer with press, release and long-press events.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data  (kind, pin_level, now_ms)
//   rsp      out        rsp_valid/rsp_ready  rsp_data  (event_res, pressed, hold_time)
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// One item per clock unless rsp stalls; rsp_valid rises as the result register loads.
// State updates as an item leaves the input register for the result register.
// Synchronous active-high reset clears both stages and all button state.
// A stalled rsp holds its result; the input register still takes one more item.
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_hold_detector_defines.svh"

module button_debounce_hold_detector
   import bdhd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [MS_W-1:0]      csr_wdata
);

   // configuration
   logic              present_ff;
   logic              active_low_ff;
   logic [MS_W-1:0]   debounce_ff;
   logic [MS_W-1:0]   hold_ms_ff;

   // button state
   logic              raw_prev_ff, raw_prev_in;
   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic              hold_rep_ff, hold_rep_in;
   event_type         event_ff, event_in;

   // pipeline
   logic              s1_valid_ff;
   req_type           s1_data_ff;
   logic              out_valid_ff;
   rsp_type           out_data_ff, out_data_in;
   logic              advance;

   logic              cur;
   logic [TIME_W-1:0] since_change;
   logic [TIME_W-1:0] since_press;
   logic              settle;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign cur = s1_data_ff.pin_level ^ active_low_ff;

   always_comb begin
      raw_prev_in    = raw_prev_ff;
      stable_in      = stable_ff;
      change_time_in = change_time_ff;
      press_start_in = press_start_ff;
      hold_rep_in    = hold_rep_ff;
      event_in       = event_ff;
      since_change   = '0;
      since_press    = '0;
      settle         = 1'b0;

      case (kind_type'(s1_data_ff.kind))
         KIND_CLEAR: begin
            event_in = EV_NONE;
         end
         KIND_START: begin
            if (present_ff) begin
               raw_prev_in = cur;
               stable_in   = cur;
            end
         end
         KIND_SAMPLE: begin
            if (present_ff) begin
               if (cur != raw_prev_ff) begin
                  change_time_in = s1_data_ff.now_ms;
               end
               since_change = s1_data_ff.now_ms - change_time_in;
               settle = (since_change > TIME_W'(debounce_ff)) && (cur != stable_ff);
               if (settle) begin
                  stable_in = cur;
                  if (cur) begin
                     event_in       = EV_PRESSED;
                     press_start_in = s1_data_ff.now_ms;
                     hold_rep_in    = 1'b0;
                  end else begin
                     event_in       = EV_RELEASED;
                     press_start_in = '0;
                  end
               end
               since_press = s1_data_ff.now_ms - press_start_in;
               if (stable_in && (hold_ms_ff != '0) && !hold_rep_in
                   && (since_press > TIME_W'(hold_ms_ff))) begin
                  event_in    = EV_HELD;
                  hold_rep_in = 1'b1;
               end
               raw_prev_in = cur;
            end
         end
         default: begin
         end
      endcase

      if (present_ff) begin
         out_data_in.event_res = event_in;
         out_data_in.pressed   = stable_in;
         out_data_in.hold_time = (stable_in && (press_start_in != '0))
                                 ? (s1_data_ff.now_ms - press_start_in) : '0;
      end else begin
         out_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff     <= 1'b1;
         active_low_ff  <= 1'b1;
         debounce_ff    <= DEBOUNCE_RESET;
         hold_ms_ff     <= HOLD_RESET;
         raw_prev_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         change_time_ff <= '0;
         press_start_ff <= '0;
         hold_rep_ff    <= 1'b0;
         event_ff       <= EV_NONE;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_BUTTON_PRESENT: present_ff    <= csr_wdata[0];
               CSR_ACTIVE_LOW:     active_low_ff <= csr_wdata[0];
               CSR_DEBOUNCE_MS:    debounce_ff   <= csr_wdata;
               CSR_HOLD_MS:        hold_ms_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            raw_prev_ff    <= raw_prev_in;
            stable_ff      <= stable_in;
            change_time_ff <= change_time_in;
            press_start_ff <= press_start_in;
            hold_rep_ff    <= hold_rep_in;
            event_ff       <= event_in;
            out_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // held event only after its press was marked as reported
   `BDHD_ASSERT_NOW(a_held_reported, clock, reset,
      event_ff == EV_HELD, hold_rep_ff, "held event without hold flag")
   // an accepted item lands in the input register
   `BDHD_ASSERT_NEXT(a_req_lands, clock, reset,
      req_valid && req_ready, s1_valid_ff, "accepted item lost")
   // an item leaving the input register becomes a result
   `BDHD_ASSERT_NEXT(a_adv_result, clock, reset,
      advance, rsp_valid, "advanced item gave no result")

endmodule

`default_nettype wire

// File: tb/sv/tb_button_debounce_hold_detector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button debounce and hold detector testbench
// Drives pin samples, clears, starts and unused kinds through the req channel
// under several register settings, predicts every result and compares it
// field by field with the rsp channel, with sender bursts, receiver stalls
// and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_button_debounce_hold_detector;
   import bdhd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;

   class button_event_predictor;
      bit        present = 1'b1;
      bit        act_low = 1'b1;
      bit [15:0] debounce = DEBOUNCE_RESET;
      bit [15:0] hold = HOLD_RESET;
      bit        raw_last;
      bit        stable;
      bit [31:0] change_t;
      bit [31:0] press_t;
      bit        hold_done;
      event_type latched = EV_NONE;
      rsp_type   expected_results[$];
      int        fail_count;

      function void set_register(csr_index_type idx, bit [15:0] value);
         case (idx)
            CSR_BUTTON_PRESENT: present = value[0];
            CSR_ACTIVE_LOW:     act_low = value[0];
            CSR_DEBOUNCE_MS:    debounce = value;
            CSR_HOLD_MS:        hold = value;
            default: ;
         endcase
      endfunction

      function void flag(string msg);
         fail_count++;
         if (fail_count <= 10) $display("mismatch: %s", msg);
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_input(req_type item);
         bit        cur;
         bit [31:0] now;
         bit [31:0] elapsed;
         rsp_type   exp_rsp;
         cur = item.pin_level ^ act_low;
         now = item.now_ms;
         case (kind_type'(item.kind))
            KIND_CLEAR: latched = EV_NONE;
            KIND_START: if (present) begin
               raw_last = cur;
               stable = cur;
            end
            KIND_SAMPLE: if (present) begin
               if (cur != raw_last) change_t = now;
               elapsed = now - change_t;
               if (elapsed > {16'd0, debounce} && cur != stable) begin
                  stable = cur;
                  if (cur) begin
                     latched = EV_PRESSED;
                     press_t = now;
                     hold_done = 1'b0;
                  end else begin
                     latched = EV_RELEASED;
                     press_t = '0;
                  end
               end
               elapsed = now - press_t;
               if (stable && hold != 0 && !hold_done && elapsed > {16'd0, hold}) begin
                  latched = EV_HELD;
                  hold_done = 1'b1;
               end
               raw_last = cur;
            end
            default: ;
         endcase
         exp_rsp = '0;
         if (present) begin
            exp_rsp.event_res = latched;
            exp_rsp.pressed = stable;
            exp_rsp.hold_time = (stable && press_t != 0) ? now - press_t : '0;
         end
         expected_results.push_back(exp_rsp);
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_rsp;
         if (expected_results.size() == 0) begin
            flag($sformatf("unexpected result ev=%0d pressed=%0d hold_time=%0d",
                           got.event_res, got.pressed, got.hold_time));
            return;
         end
         exp_rsp = expected_results.pop_front();
         if (got.event_res !== exp_rsp.event_res)
            flag($sformatf("event_res exp %0d got %0d", exp_rsp.event_res, got.event_res));
         if (got.pressed !== exp_rsp.pressed)
            flag($sformatf("pressed exp %0d got %0d", exp_rsp.pressed, got.pressed));
         if (got.hold_time !== exp_rsp.hold_time)
            flag($sformatf("hold_time exp %0d got %0d", exp_rsp.hold_time, got.hold_time));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MS_W-1:0]      csr_wdata = '0;

   button_event_predictor pred = new();

   int unsigned cycle_count;
   int unsigned rsp_count;
   int unsigned burst_left;
   bit          gaps_on;
   bit [31:0]   clock_ms;
   bit          target_level;
   int unsigned bounce_left;

   button_debounce_hold_detector uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_button_debounce_hold_detector NOT OK");
         $finish;
      end
   end

   // transfers are observed at the falling edge, where all signals are settled
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) pred.note_input(req_data);
         if (rsp_valid && rsp_ready) begin
            pred.check_result(rsp_data);
            rsp_count++;
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int unsigned rx_cycle;
      int unsigned stall_mode;
      bit          held_off;
      rx_cycle = 0;
      stall_mode = 0;
      held_off = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && rsp_count >= 400) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (rx_cycle % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 99) < 85);
            endcase
            rx_cycle++;
            @(posedge clock);
         end
      end
   end

   task automatic send_item(input req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_data <= item;
      req_valid <= 1'b1;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_fields(input kind_type kind, input bit pin, input bit [31:0] now);
      req_type item;
      item.kind = kind;
      item.pin_level = pin;
      item.now_ms = now;
      send_item(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pred.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input bit present, input bit act_low,
                                 input bit [15:0] debounce, input bit [15:0] hold);
      csr_index_type idx;
      bit [15:0]     value;
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_BUTTON_PRESENT: value = {15'd0, present};
            CSR_ACTIVE_LOW:     value = {15'd0, act_low};
            CSR_DEBOUNCE_MS:    value = debounce;
            default:            value = hold;
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         pred.set_register(idx, value);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic bit [31:0] time_step();
      int unsigned sel;
      bit [31:0]   deb;
      bit [31:0]   hld;
      sel = $urandom_range(0, 99);
      deb = pred.debounce;
      hld = pred.hold;
      if (sel < 55) return $urandom_range(0, deb / 8 + 1);
      if (sel < 85) return $urandom_range(deb / 2, deb + deb / 2 + 2);
      if (sel < 97) return $urandom_range(deb, deb + hld + hld / 2 + 2);
      return 0;
   endfunction

   task automatic run_random(input int unsigned count);
      int unsigned sel;
      bit          pin;
      for (int unsigned n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 80) begin
            if ($urandom_range(0, 99) < 6) begin
               target_level = ~target_level;
               bounce_left = $urandom_range(0, 4);
            end
            if (bounce_left > 0) begin
               pin = 1'($urandom_range(0, 1));
               bounce_left--;
            end else begin
               pin = target_level;
            end
            clock_ms = clock_ms + time_step();
            send_fields(KIND_SAMPLE, pin, clock_ms);
         end else if (sel < 87) begin
            send_fields(KIND_CLEAR, 1'($urandom_range(0, 1)), clock_ms);
         end else if (sel < 93) begin
            pin = 1'($urandom_range(0, 1));
            target_level = pin;
            send_fields(KIND_START, pin, clock_ms);
         end else if (sel < 96) begin
            send_fields(KIND_UNUSED, 1'($urandom_range(0, 1)), $urandom);
         end else begin
            send_fields(KIND_SAMPLE, 1'($urandom_range(0, 1)), $urandom);
         end
      end
   endtask

   task automatic run_phase(input bit present, input bit act_low, input bit [15:0] debounce,
                            input bit [15:0] hold, input int unsigned count,
                            input bit gaps, input bit [31:0] start_ms);
      wait_idle();
      write_settings(present, act_low, debounce, hold);
      gaps_on = gaps;
      clock_ms = start_ms;
      run_random(count);
   endtask

   initial begin
      burst_left = 0;
      gaps_on = 1'b1;
      clock_ms = 0;
      target_level = 1'b1;
      bounce_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: debounce edges, hold edge, bounce, clear, start, wrap
      write_settings(1'b1, 1'b1, 16'd50, 16'd100);
      send_fields(KIND_START, 1'b1, 32'd10);
      send_fields(KIND_SAMPLE, 1'b0, 32'd20);
      send_fields(KIND_SAMPLE, 1'b0, 32'd70);
      send_fields(KIND_SAMPLE, 1'b0, 32'd71);
      send_fields(KIND_SAMPLE, 1'b0, 32'd171);
      send_fields(KIND_SAMPLE, 1'b0, 32'd172);
      send_fields(KIND_SAMPLE, 1'b0, 32'd400);
      send_fields(KIND_CLEAR, 1'b0, 32'd180);
      send_fields(KIND_SAMPLE, 1'b1, 32'd200);
      send_fields(KIND_SAMPLE, 1'b0, 32'd210);
      send_fields(KIND_SAMPLE, 1'b1, 32'd220);
      send_fields(KIND_SAMPLE, 1'b1, 32'd271);
      send_fields(KIND_UNUSED, 1'b0, 32'hFFFF_FFFF);
      send_fields(KIND_START, 1'b0, 32'd300);
      send_fields(KIND_SAMPLE, 1'b0, 32'd301);
      send_fields(KIND_CLEAR, 1'b1, 32'd0);
      send_fields(KIND_SAMPLE, 1'b1, 32'hFFFF_FFF0);
      send_fields(KIND_SAMPLE, 1'b1, 32'h0000_0030);
      send_fields(KIND_SAMPLE, 1'b0, 32'hFFFF_FFFF);
      send_fields(KIND_SAMPLE, 1'b0, 32'h0000_0040);
      send_fields(KIND_SAMPLE, 1'b0, 32'h0000_0041);
      send_fields(KIND_UNUSED, 1'b1, 32'd0);
      send_fields(KIND_CLEAR, 1'b1, 32'hFFFF_FFFF);

      run_phase(1'b1, 1'b1, 16'd50, 16'd0, 300, 1'b1, 32'd1000);
      run_phase(1'b1, 1'b0, 16'd0, 16'd0, 300, 1'b0, 32'd5);
      run_phase(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 250, 1'b1, 32'hFFF0_0000);
      run_phase(1'b0, 1'b0, 16'd20, 16'd30, 200, 1'b1, 32'd77);
      run_phase(1'b1, 1'b0, 16'd20, 16'd200, 300, 1'b1, 32'd500);
      // polarity flip keeps state as pressed bits
      run_phase(1'b1, 1'b1, 16'd20, 16'd200, 300, 1'b0, clock_ms);
      run_phase(1'b1, 1'b0, 16'd3, 16'd1, 300, 1'b1, 32'hFFFF_FF00);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pred.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pred.fail_count == 0 && pred.pending() == 0) begin
         $display("tb_button_debounce_hold_detector OK");
      end else begin
         $display("tb_button_debounce_hold_detector NOT OK");
      end
      $finish;
   end

endmodule
